// ===== rtl/multitap_text_entry_core_macros.svh =====
`ifndef MULTITAP_TEXT_ENTRY_CORE_MACROS_SVH
`define MULTITAP_TEXT_ENTRY_CORE_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define MTE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define MTE_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mte_pkg.sv =====
`default_nettype none

package mte_pkg;

    localparam int MAX_TEXT_DEF = 32;
    localparam logic [15:0] TAP_TIMEOUT_RST = 16'd900;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_KEY   = 2'd1,
        CMD_START = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        EV_IDLE      = 2'd0,
        EV_CHANGED   = 2'd1,
        EV_DONE      = 2'd2,
        EV_CANCELLED = 2'd3
    } t_event;

    localparam logic [3:0] KEY_A    = 4'd10;
    localparam logic [3:0] KEY_B    = 4'd11;
    localparam logic [3:0] KEY_C    = 4'd12;
    localparam logic [3:0] KEY_D    = 4'd13;
    localparam logic [3:0] KEY_STAR = 4'd14;
    localparam logic [3:0] KEY_HASH = 4'd15;

    localparam logic CFG_START_DIGITS = 1'b0;
    localparam logic CFG_TAP_TIMEOUT  = 1'b1;

    localparam logic [7:0] ASCII_ZERO = 8'h30;

    function automatic logic [2:0] set_len(input logic [3:0] digit);
        logic [2:0] len;
        unique case (digit)
            4'd0:          len = 3'd2;
            4'd1:          len = 3'd1;
            4'd7, 4'd9:    len = 3'd5;
            default:       len = 3'd4;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] char_of(input logic [3:0] digit, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        unique case (digit)
            4'd0: c = (pos == 3'd0) ? "0" : (pos == 3'd1) ? " " : 8'h00;
            4'd1: c = (pos == 3'd0) ? "1" : 8'h00;
            4'd7: begin
                unique case (pos)
                    3'd0: c = "p";
                    3'd1: c = "q";
                    3'd2: c = "r";
                    3'd3: c = "s";
                    3'd4: c = "7";
                    default: c = 8'h00;
                endcase
            end
            4'd9: begin
                unique case (pos)
                    3'd0: c = "w";
                    3'd1: c = "x";
                    3'd2: c = "y";
                    3'd3: c = "z";
                    3'd4: c = "9";
                    default: c = 8'h00;
                endcase
            end
            4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd8: begin
                // letter sets of three run contiguously in ASCII
                if (pos < 3'd3) begin
                    c = 8'h61 + 8'(3 * (digit - 4'd2)) + ((digit == 4'd8) ? 8'd1 : 8'd0)
                        + 8'(pos);
                end else if (pos == 3'd3) begin
                    c = ASCII_ZERO + 8'(digit);
                end
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mte_req_if.sv =====
`default_nettype none

interface mte_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [3:0] key_code;
    logic [4:0] read_index;

    modport source (output valid, cmd, key_code, read_index, input ready);
    modport sink   (input valid, cmd, key_code, read_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/mte_rsp_if.sv =====
`default_nettype none

interface mte_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    logic [5:0] text_length;
    logic [7:0] pending_char;
    logic [7:0] read_char;
    logic       overflow;

    modport source (output valid, event_res, text_length, pending_char, read_char, overflow,
                    input ready);
    modport sink   (input valid, event_res, text_length, pending_char, read_char, overflow,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/multitap_text_entry_core.sv =====
// Multi-tap keypad text entry.
// Request channel i_req carries cmd (tick, key press, start, read), key_code
// and read_index; every request yields exactly one response on o_rsp with the
// event, committed text length, pending character, the character at
// read_index after the request, and an overflow flag.
// Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_index
// (0 start_digits_only, 1 tap_timeout_ticks). The user must write it only
// while no request is in flight; the block does not enforce this.
// Throughput: one request per cycle while o_rsp.ready is high; the input
// register, the combinational update of the entry state and text store write,
// and the response register form a two-stage pipeline. The text store read
// port is fed from read_index on accept, forwarding the write in flight.
// Reset clears the text length, the pending character, the idle counter and
// the mode; text store contents are not cleared and need no clearing pass.
// When o_rsp.ready is low the response register holds, the update stage
// holds its request, and i_req.ready drops once both stages are full.
`default_nettype none

`include "multitap_text_entry_core_macros.svh"

module multitap_text_entry_core
    import mte_pkg::*;
#(
    parameter int MAX_TEXT = MAX_TEXT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_wdata,
    mte_req_if.sink          i_req,
    mte_rsp_if.source        o_rsp
);

    localparam int CW   = $clog2(MAX_TEXT + 1);
    localparam int AW   = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
    localparam int CMPW = (CW > 5) ? CW : 5;

    logic        r_start_digits;
    logic [15:0] r_timeout;

    logic        r_in_valid;
    t_cmd        r_cmd;
    logic [3:0]  r_key;
    logic [4:0]  r_ridx;
    logic        r_fwd_hit;
    logic [7:0]  r_fwd_data;

    logic [CW-1:0] r_count;
    logic          r_pend_valid;
    logic [3:0]    r_pend_digit;
    logic [2:0]    r_tap;
    logic [15:0]   r_idle;
    logic          r_digits_mode;

    logic [CW-1:0] n_count;
    logic          n_pend_valid;
    logic [3:0]    n_pend_digit;
    logic [2:0]    n_tap;
    logic [15:0]   n_idle;
    logic          n_digits_mode;

    logic        r_out_valid;
    t_event      r_ev;
    logic [5:0]  r_len;
    logic [7:0]  r_pchar;
    logic [7:0]  r_rchar;
    logic        r_ovf;

    logic        accept;
    logic        fire;
    logic        in_ready;
    t_event      ev;
    logic        ovf;
    logic        app_req;
    logic [7:0]  app_char;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]  cur_char;
    logic [7:0]  new_pchar;
    logic [7:0]  ram_q;
    logic [7:0]  rd_data;
    logic [7:0]  rchar;
    logic [2:0]  tap_inc;

    assign fire     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign in_ready = !r_in_valid || fire;
    assign accept   = i_req.valid && in_ready;
    assign i_req.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_digits <= 1'b0;
            r_timeout      <= TAP_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_START_DIGITS: r_start_digits <= i_cfg_wdata[0];
                CFG_TAP_TIMEOUT:  r_timeout      <= i_cfg_wdata;
                default:          r_timeout      <= r_timeout;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd      <= t_cmd'(i_req.cmd);
            r_key      <= i_req.key_code;
            r_ridx     <= i_req.read_index;
            r_fwd_hit  <= wr_en && (wr_addr == AW'(i_req.read_index));
            r_fwd_data <= app_char;
        end
    end

    assign cur_char = r_pend_valid ? char_of(r_pend_digit, r_tap) : 8'h00;
    assign tap_inc  = ((r_tap + 3'd1) == set_len(r_key)) ? 3'd0 : r_tap + 3'd1;

    always_comb begin
        n_count       = r_count;
        n_pend_valid  = r_pend_valid;
        n_pend_digit  = r_pend_digit;
        n_tap         = r_tap;
        n_idle        = r_idle;
        n_digits_mode = r_digits_mode;
        ev            = EV_IDLE;
        app_req       = 1'b0;
        app_char      = cur_char;
        unique case (r_cmd)
            CMD_TICK: begin
                if (r_idle != 16'hFFFF) begin
                    n_idle = r_idle + 16'd1;
                end
                if (r_pend_valid && (n_idle > r_timeout)) begin
                    app_req      = 1'b1;
                    n_pend_valid = 1'b0;
                    n_tap        = 3'd0;
                    ev           = EV_CHANGED;
                end
            end
            CMD_KEY: begin
                unique case (r_key)
                    KEY_HASH: begin
                        app_req      = r_pend_valid;
                        n_pend_valid = 1'b0;
                        if (r_pend_valid) begin
                            n_tap = 3'd0;
                        end
                        ev = EV_DONE;
                    end
                    KEY_D: begin
                        ev = EV_CANCELLED;
                    end
                    KEY_STAR: begin
                        if (r_pend_valid) begin
                            n_pend_valid = 1'b0;
                            n_tap        = 3'd0;
                        end else if (r_count != '0) begin
                            n_count = r_count - CW'(1);
                        end
                        ev = EV_CHANGED;
                    end
                    KEY_A: begin
                        app_req      = r_pend_valid;
                        n_pend_valid = 1'b0;
                        if (r_pend_valid) begin
                            n_tap = 3'd0;
                        end
                        n_digits_mode = !r_digits_mode;
                        ev            = EV_CHANGED;
                    end
                    KEY_B, KEY_C: begin
                        ev = EV_IDLE;
                    end
                    default: begin
                        if (r_digits_mode) begin
                            // no pending character can exist in digits mode
                            app_req  = 1'b1;
                            app_char = ASCII_ZERO + 8'(r_key);
                        end else begin
                            if (r_pend_valid && (r_pend_digit == r_key)) begin
                                n_tap = tap_inc;
                            end else begin
                                app_req      = r_pend_valid;
                                n_pend_valid = 1'b1;
                                n_pend_digit = r_key;
                                n_tap        = 3'd0;
                            end
                            n_idle = 16'd0;
                        end
                        ev = EV_CHANGED;
                    end
                endcase
            end
            CMD_START: begin
                n_count       = '0;
                n_pend_valid  = 1'b0;
                n_pend_digit  = 4'd0;
                n_tap         = 3'd0;
                n_idle        = 16'd0;
                n_digits_mode = r_start_digits;
            end
            CMD_READ: begin
                ev = EV_IDLE;
            end
            default: begin
                ev = EV_IDLE;
            end
        endcase

        wr_en = 1'b0;
        ovf   = 1'b0;
        if (app_req) begin
            if (r_count < CW'(MAX_TEXT)) begin
                wr_en   = r_in_valid && fire;
                n_count = r_count + CW'(1);
            end else begin
                ovf = 1'b1;
            end
        end
    end

    assign wr_addr = AW'(r_count);

    mte_ram #(
        .WIDTH (8),
        .DEPTH (MAX_TEXT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (app_char),
        .i_re    (accept),
        .i_raddr (AW'(i_req.read_index)),
        .o_rdata (ram_q)
    );

    always_comb begin
        if (wr_en && (wr_addr == AW'(r_ridx))) begin
            rd_data = app_char;
        end else if (r_fwd_hit) begin
            rd_data = r_fwd_data;
        end else begin
            rd_data = ram_q;
        end
        rchar = (CMPW'(r_ridx) < CMPW'(n_count)) ? rd_data : 8'h00;
    end

    assign new_pchar = n_pend_valid ? char_of(n_pend_digit, n_tap) : 8'h00;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_pend_valid  <= 1'b0;
            r_pend_digit  <= 4'd0;
            r_tap         <= 3'd0;
            r_idle        <= 16'd0;
            r_digits_mode <= 1'b0;
        end else if (fire) begin
            r_count       <= n_count;
            r_pend_valid  <= n_pend_valid;
            r_pend_digit  <= n_pend_digit;
            r_tap         <= n_tap;
            r_idle        <= n_idle;
            r_digits_mode <= n_digits_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_ev    <= ev;
            r_len   <= 6'(n_count);
            r_pchar <= new_pchar;
            r_rchar <= rchar;
            r_ovf   <= ovf;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.event_res    = r_ev;
    assign o_rsp.text_length  = r_len;
    assign o_rsp.pending_char = r_pchar;
    assign o_rsp.read_char    = r_rchar;
    assign o_rsp.overflow     = r_ovf;

    `MTE_ASSERT(a_digits_no_pend, i_clk, i_rst_n, r_digits_mode |-> !r_pend_valid, "pending char in digits mode")
    `MTE_ASSERT(a_count_cap, i_clk, i_rst_n, r_count <= CW'(MAX_TEXT), "text count above capacity")
    `MTE_ASSERT(a_tap_range, i_clk, i_rst_n, r_pend_valid |-> (r_tap < set_len(r_pend_digit)), "tap position out of set")
    `MTE_ASSERT_NEXT(a_ovf_full, i_clk, i_rst_n, fire && ovf, r_count == CW'(MAX_TEXT), "overflow with room in store")

endmodule

`default_nettype wire

// ===== rtl/mte_ram.sv =====
`default_nettype none

module mte_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
